>>> sv/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants for the grid reachability search
// Grid geometry, field widths, command codes, register indexes and the
// 8-neighbor step tables used by the search sequencer.
// ----------------------------------------------------------------------------
package grc_pkg;

   localparam int GRID_W      = 64;
   localparam int GRID_H      = 64;
   localparam int CELLS       = GRID_W * GRID_H;
   localparam int CELL_W      = 12;
   localparam int DIST_W      = 16;
   localparam int COST_W      = 12;
   localparam int KEY_W       = DIST_W + CELL_W;
   localparam int QUEUE_DEPTH = 8192;
   localparam int QIDX_W      = 13;
   localparam int FILL_W      = 14;
   localparam int COUNT_W     = 13;

   // command codes
   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_MOVE_RANGE    = 2'd0;
   localparam logic [1:0] REG_MIN_RANGE     = 2'd1;
   localparam logic [1:0] REG_STRAIGHT_COST = 2'd2;
   localparam logic [1:0] REG_DIAGONAL_COST = 2'd3;

   // neighbor offsets, 7-bit two's complement
   localparam logic [6:0] STEP_DX [8] = '{7'h7F, 7'h00, 7'h01, 7'h7F,
                                          7'h01, 7'h7F, 7'h00, 7'h01};
   localparam logic [6:0] STEP_DZ [8] = '{7'h7F, 7'h7F, 7'h7F, 7'h00,
                                          7'h00, 7'h01, 7'h01, 7'h01};
   localparam logic       STEP_DIAG [8] = '{1'b1, 1'b0, 1'b1, 1'b0,
                                            1'b0, 1'b1, 1'b0, 1'b1};

   typedef struct packed {
      logic              clear;
      logic              push;
      logic              pop;
      logic [KEY_W-1:0]  key;
   } heap_req_type;

   typedef struct packed {
      logic              busy;
      logic [FILL_W-1:0] fill;
      logic [KEY_W-1:0]  top;
   } heap_stat_type;

   typedef struct packed {
      logic              visited;
      logic              dvalid;
      logic [DIST_W-1:0] best;
   } cell_state_type;

endpackage

>>> sv/grc_heap.sv
// ----------------------------------------------------------------------------
// grc_heap: binary min-heap of (distance, cell) keys
// Keys live in a single-port-read memory; push sifts up and pop sifts down,
// one compare per step under a small sequencer.
// ----------------------------------------------------------------------------
module grc_heap
   import grc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  heap_req_type  req,
   output heap_stat_type stat
);

   typedef enum logic [8:0] {
      H_IDLE     = 9'b000000001,
      H_PUSH_RD  = 9'b000000010,
      H_PUSH_CMP = 9'b000000100,
      H_POP_LAST = 9'b000001000,
      H_POP_GETL = 9'b000010000,
      H_POP_RDL  = 9'b000100000,
      H_POP_RDR  = 9'b001000000,
      H_POP_CMP  = 9'b010000000,
      H_POP_FIN  = 9'b100000000
   } heap_state_type;

   logic [KEY_W-1:0] mem [QUEUE_DEPTH];
   logic [KEY_W-1:0] rdata_ff;
   logic [QIDX_W-1:0] raddr, waddr;
   logic [KEY_W-1:0] wdata;
   logic              we;

   heap_state_type    state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [QIDX_W-1:0] idx_ff, idx_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  top_ff, top_in;
   logic [KEY_W-1:0]  last_ff, last_in;
   logic [KEY_W-1:0]  lch_ff, lch_in;
   logic              rv_ff, rv_in;

   logic [QIDX_W-1:0] parent;
   logic [FILL_W-1:0] child;
   logic [FILL_W:0]   child_r;

   assign parent  = (idx_ff - QIDX_W'(1)) >> 1;
   assign child   = {idx_ff, 1'b1};
   assign child_r = {1'b0, child} + (FILL_W+1)'(1);

   // memory ports
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // sift sequencer
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      top_in   = top_ff;
      last_in  = last_ff;
      lch_in   = lch_ff;
      rv_in    = rv_ff;
      raddr    = '0;
      waddr    = idx_ff;
      wdata    = key_ff;
      we       = 1'b0;
      case (state_ff)
         H_IDLE: begin
            if (req.clear) begin
               fill_in = '0;
            end else if (req.push) begin
               idx_in   = fill_ff[QIDX_W-1:0];
               fill_in  = fill_ff + FILL_W'(1);
               key_in   = req.key;
               state_in = H_PUSH_RD;
            end else if (req.pop) begin
               fill_in  = fill_ff - FILL_W'(1);
               state_in = H_POP_LAST;
            end
         end
         H_PUSH_RD: begin
            if (idx_ff == '0) begin
               we       = 1'b1;
               state_in = H_IDLE;
            end else begin
               raddr    = parent;
               state_in = H_PUSH_CMP;
            end
         end
         H_PUSH_CMP: begin
            we = 1'b1;
            if (rdata_ff <= key_ff) begin
               state_in = H_IDLE;
            end else begin
               wdata    = rdata_ff;
               idx_in   = parent;
               state_in = H_PUSH_RD;
            end
         end
         H_POP_LAST: begin
            top_in   = rdata_ff;
            raddr    = fill_ff[QIDX_W-1:0];
            state_in = H_POP_GETL;
         end
         H_POP_GETL: begin
            last_in  = rdata_ff;
            idx_in   = '0;
            state_in = H_POP_RDL;
         end
         H_POP_RDL: begin
            if (child >= fill_ff) begin
               state_in = H_POP_FIN;
            end else begin
               raddr    = child[QIDX_W-1:0];
               state_in = H_POP_RDR;
            end
         end
         H_POP_RDR: begin
            lch_in   = rdata_ff;
            raddr    = child_r[QIDX_W-1:0];
            rv_in    = child_r < {1'b0, fill_ff};
            state_in = H_POP_CMP;
         end
         H_POP_CMP: begin
            wdata = lch_ff;
            if (rv_ff && (rdata_ff < lch_ff)) begin
               wdata = rdata_ff;
            end
            if (wdata >= last_ff) begin
               state_in = H_POP_FIN;
            end else begin
               we       = 1'b1;
               idx_in   = (rv_ff && (rdata_ff < lch_ff)) ? child_r[QIDX_W-1:0]
                                                         : child[QIDX_W-1:0];
               state_in = H_POP_RDL;
            end
         end
         H_POP_FIN: begin
            wdata    = last_ff;
            we       = (fill_ff != '0);
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      idx_ff  <= idx_in;
      key_ff  <= key_in;
      top_ff  <= top_in;
      last_ff <= last_in;
      lch_ff  <= lch_in;
      rv_ff   <= rv_in;
   end

   assign stat.busy = (state_ff != H_IDLE);
   assign stat.fill = fill_ff;
   assign stat.top  = top_ff;

endmodule

>>> sv/grid_reachable_cells_within_range.sv
// A write or an unused command responds in the cycle after its accept; a query first reads the
// cell state memory, then responds from S_QRY. A search clears the 4096-entry cell state memory,
// then pops the queue until it is empty; each settled cell checks its 8 neighbors and pushes
// each neighbor that it relaxes.
// Throughput: one transaction at a time; the heap and cell memories set the pace.
// Reset: synchronous; a clearing pass of both grid memories follows,
// during which req_tready stays low (register writes are still taken).
// ----------------------------------------------------------------------------
// grid_reachable_cells_within_range: bounded-range reachability search
// Holds a passability grid, runs a Dijkstra search over 8 neighbors from a
// start cell with a heap-based queue, and answers per-cell queries.
// ----------------------------------------------------------------------------
module grid_reachable_cells_within_range
   import grc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // command[1:0], cell_x[7:2], cell_z[13:8],
                                    // passable_bit[14], zero[15]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // reachable[0], distance[16:1],
                                    // reachable_count[29:17], queue_overflow[30], zero[31]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   typedef enum logic [14:0] {
      S_INIT  = 15'b000000000000001,
      S_IDLE  = 15'b000000000000010,
      S_QRY   = 15'b000000000000100,
      S_CLR   = 15'b000000000001000,
      S_START = 15'b000000000010000,
      S_POP   = 15'b000000000100000,
      S_POPW  = 15'b000000001000000,
      S_CHK   = 15'b000000010000000,
      S_N0    = 15'b000000100000000,
      S_N1    = 15'b000001000000000,
      S_N2    = 15'b000010000000000,
      S_N3    = 15'b000100000000000,
      S_N4    = 15'b001000000000000,
      S_N5    = 15'b010000000000000,
      S_DONE  = 15'b100000000000000
   } state_type;

   // configuration registers
   logic [DIST_W-1:0] move_range_ff, min_range_ff;
   logic [COST_W-1:0] straight_cost_ff, diagonal_cost_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         move_range_ff    <= DIST_W'(0);
         min_range_ff     <= DIST_W'(50);
         straight_cost_ff <= COST_W'(1000);
         diagonal_cost_ff <= COST_W'(1414);
      end else if (csr_valid) begin
         case (csr_index)
            REG_MOVE_RANGE:    move_range_ff    <= csr_data;
            REG_MIN_RANGE:     min_range_ff     <= csr_data;
            REG_STRAIGHT_COST: straight_cost_ff <= csr_data[COST_W-1:0];
            REG_DIAGONAL_COST: diagonal_cost_ff <= csr_data[COST_W-1:0];
            default: ;
         endcase
      end
   end

   // request fields
   logic [1:0]        req_cmd;
   logic [CELL_W-1:0] req_cell;
   logic              req_bit;
   logic              req_fire;

   assign req_cmd  = req_tdata[1:0];
   assign req_cell = {req_tdata[7:2], req_tdata[13:8]};
   assign req_bit  = req_tdata[14];
   assign req_fire = req_tvalid && req_tready;

   // control state
   state_type          state_ff, state_in;
   logic [CELL_W-1:0]  sweep_ff, sweep_in;
   logic [2:0]         dir_ff, dir_in;
   logic [KEY_W-1:0]   cur_ff, cur_in;
   logic [CELL_W-1:0]  start_ff, start_in;
   logic [COUNT_W-1:0] found_ff, found_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   // memories
   logic              pass_mem [CELLS];
   cell_state_type    cell_mem [CELLS];
   logic              pass_rdata_ff;
   cell_state_type    cell_rdata_ff;
   logic [CELL_W-1:0] pass_raddr, pass_waddr, cell_raddr, cell_waddr;
   logic              pass_we, pass_wdata, cell_we;
   cell_state_type    cell_wdata;

   always_ff @(posedge clock) begin
      if (pass_we) begin
         pass_mem[pass_waddr] <= pass_wdata;
      end
      pass_rdata_ff <= pass_mem[pass_raddr];
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rdata_ff <= cell_mem[cell_raddr];
   end

   // heap
   heap_req_type  hreq;
   heap_stat_type hstat;

   grc_heap u_heap (
      .clock (clock),
      .reset (reset),
      .req   (hreq),
      .stat  (hstat)
   );

   // neighbor geometry of the current cell
   logic [5:0]        gx, gz;
   logic [6:0]        nx, nz;
   logic              nb_out, diag;
   logic [CELL_W-1:0] nb_cell, corner_a, corner_b;
   logic [DIST_W:0]   nd;
   logic [DIST_W-1:0] cur_dist;

   assign cur_dist = cur_ff[KEY_W-1:CELL_W];
   assign gx       = cur_ff[CELL_W-1:6];
   assign gz       = cur_ff[5:0];
   assign nx       = {1'b0, gx} + STEP_DX[dir_ff];
   assign nz       = {1'b0, gz} + STEP_DZ[dir_ff];
   assign nb_out   = nx[6] || nz[6];
   assign diag     = STEP_DIAG[dir_ff];
   assign nb_cell  = {nx[5:0], nz[5:0]};
   assign corner_a = {nx[5:0], gz};
   assign corner_b = {gx, nz[5:0]};
   assign nd       = {1'b0, cur_dist}
                   + (DIST_W+1)'(diag ? diagonal_cost_ff : straight_cost_ff);

   // sequencer
   always_comb begin
      logic step_done;
      step_done    = 1'b0;
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      dir_in       = dir_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      found_in     = found_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pass_raddr   = nb_cell;
      pass_waddr   = sweep_ff;
      pass_wdata   = 1'b0;
      pass_we      = 1'b0;
      cell_raddr   = nb_cell;
      cell_waddr   = sweep_ff;
      cell_wdata   = '0;
      cell_we      = 1'b0;
      hreq         = '0;
      case (state_ff)
         S_INIT: begin
            pass_we  = 1'b1;
            cell_we  = 1'b1;
            sweep_in = sweep_ff + CELL_W'(1);
            if (sweep_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cell_raddr = req_cell;
            if (req_fire) begin
               case (req_cmd)
                  CMD_WRITE: begin
                     pass_we      = 1'b1;
                     pass_waddr   = req_cell;
                     pass_wdata   = req_bit;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
                  CMD_SEARCH: begin
                     hreq.clear = 1'b1;
                     found_in   = '0;
                     ovf_in     = 1'b0;
                     sweep_in   = '0;
                     start_in   = req_cell;
                     state_in   = S_CLR;
                  end
                  CMD_QUERY: begin
                     state_in = S_QRY;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
               endcase
            end
         end
         S_QRY: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            if (cell_rdata_ff.visited) begin
               rsp_data_in[0]    = 1'b1;
               rsp_data_in[16:1] = cell_rdata_ff.best;
            end
            state_in = S_IDLE;
         end
         S_CLR: begin
            cell_we  = 1'b1;
            sweep_in = sweep_ff + CELL_W'(1);
            if (sweep_ff == '1) begin
               state_in = (move_range_ff < min_range_ff) ? S_DONE : S_START;
            end
         end
         S_START: begin
            cell_we           = 1'b1;
            cell_waddr        = start_ff;
            cell_wdata.dvalid = 1'b1;
            hreq.push         = 1'b1;
            hreq.key          = {DIST_W'(0), start_ff};
            state_in          = S_POP;
         end
         S_POP: begin
            if (!hstat.busy) begin
               if (hstat.fill == '0) begin
                  state_in = S_DONE;
               end else begin
                  hreq.pop = 1'b1;
                  state_in = S_POPW;
               end
            end
         end
         S_POPW: begin
            cell_raddr = hstat.top[CELL_W-1:0];
            if (!hstat.busy) begin
               cur_in   = hstat.top;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            // drop stale, visited and out-of-range entries
            if ((cur_dist > cell_rdata_ff.best) || cell_rdata_ff.visited
                || (cur_dist > move_range_ff)) begin
               state_in = S_POP;
            end else begin
               cell_we            = 1'b1;
               cell_waddr         = cur_ff[CELL_W-1:0];
               cell_wdata         = cell_rdata_ff;
               cell_wdata.visited = 1'b1;
               found_in           = found_ff + COUNT_W'(1);
               dir_in             = '0;
               state_in           = S_N0;
            end
         end
         S_N0: begin
            if (nb_out) begin
               step_done = 1'b1;
            end else begin
               state_in = S_N1;
            end
         end
         S_N1: begin
            if (!pass_rdata_ff) begin
               step_done = 1'b1;
            end else if (diag) begin
               pass_raddr = corner_a;
               state_in   = S_N2;
            end else begin
               state_in = S_N4;
            end
         end
         S_N2: begin
            if (!pass_rdata_ff) begin
               step_done = 1'b1;
            end else begin
               pass_raddr = corner_b;
               state_in   = S_N3;
            end
         end
         S_N3: begin
            if (!pass_rdata_ff) begin
               step_done = 1'b1;
            end else begin
               state_in = S_N4;
            end
         end
         S_N4: begin
            // relax the neighbor
            if (nd > {1'b0, move_range_ff}) begin
               step_done = 1'b1;
            end else if (cell_rdata_ff.dvalid && (nd[DIST_W-1:0] >= cell_rdata_ff.best)) begin
               step_done = 1'b1;
            end else if (hstat.fill >= FILL_W'(QUEUE_DEPTH)) begin
               ovf_in    = 1'b1;
               step_done = 1'b1;
            end else begin
               cell_we           = 1'b1;
               cell_waddr        = nb_cell;
               cell_wdata        = cell_rdata_ff;
               cell_wdata.dvalid = 1'b1;
               cell_wdata.best   = nd[DIST_W-1:0];
               hreq.push         = 1'b1;
               hreq.key          = {nd[DIST_W-1:0], nb_cell};
               state_in          = S_N5;
            end
         end
         S_N5: begin
            if (!hstat.busy) begin
               step_done = 1'b1;
            end
         end
         S_DONE: begin
            rsp_valid_in       = 1'b1;
            rsp_data_in        = '0;
            rsp_data_in[29:17] = found_ff;
            rsp_data_in[30]    = ovf_ff;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // advance to the next direction, or back to S_POP after the last one
      if (step_done) begin
         if (dir_ff == 3'd7) begin
            state_in = S_POP;
         end else begin
            dir_in   = dir_ff + 3'd1;
            state_in = S_N0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         found_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         found_ff     <= found_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dir_ff      <= dir_in;
      cur_ff      <= cur_in;
      start_ff    <= start_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      hstat.fill <= FILL_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_push_idle: assert property (@(posedge clock) disable iff (reset)
      hreq.push |-> !hstat.busy && (hstat.fill < FILL_W'(QUEUE_DEPTH)))
      else $error("push while heap busy or full");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[29:17] != '0)) |-> (move_range_ff >= min_range_ff))
      else $error("cells reported with range below minimum");
`endif

endmodule
